// ----- rtl/core/time_of_day_text_parser_core_defines.svh -----
// Assertion macros for the time-of-day text parser core.
// Depends on nothing; the using module must provide aclk and aresetn.
`ifndef TIME_OF_DAY_TEXT_PARSER_CORE_DEFINES_SVH
`define TIME_OF_DAY_TEXT_PARSER_CORE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TODTP_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("todtp assertion failed");

// Consequence in the cycle after the condition.
`define TODTP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("todtp assertion failed");

`endif

// ----- rtl/core/todtp_pkg.sv -----
// Shared types and constants of the time-of-day text parser core.
// Depends on nothing.
package todtp_pkg;

    typedef enum logic [3:0] {
        PH_HOUR0 = 4'd0,
        PH_HOUR  = 4'd1,
        PH_MIN0  = 4'd2,
        PH_MIN   = 4'd3,
        PH_SEC0  = 4'd4,
        PH_SEC   = 4'd5,
        PH_HUND0 = 4'd6,
        PH_HUND  = 4'd7,
        PH_TERM  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        SUF_NONE = 2'd0,
        SUF_AM   = 2'd1,
        SUF_PM   = 2'd2
    } suffix_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic       valid_res;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] hundredths;
    } out_item_t;

    typedef struct packed {
        phase_t     phase;
        logic [6:0] hour_acc;
        logic [6:0] minute_acc;
        logic [6:0] second_acc;
        logic [6:0] hundredths_acc;
        suffix_t    suffix;
        logic       finished;
    } parse_state_t;

    localparam logic [6:0] HOUR_MAX_24    = 7'd24;
    localparam logic [6:0] HOUR_MAX_12    = 7'd12;
    localparam logic [6:0] MINSEC_MAX     = 7'd60;
    localparam logic [6:0] HUNDREDTHS_MAX = 7'd99;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_HOUR0,
        hour_acc:       7'd0,
        minute_acc:     7'd0,
        second_acc:     7'd0,
        hundredths_acc: 7'd0,
        suffix:         SUF_NONE,
        finished:       1'b0
    };

endpackage

// ----- rtl/core/todtp_step.sv -----
// Per-character parser step: next parser state and the result, if any.
// Depends on todtp_pkg.
module todtp_step (
    input  todtp_pkg::parse_state_t cur_state,
    input  todtp_pkg::in_item_t     item,
    output todtp_pkg::parse_state_t state_next,
    output logic                    emit,
    output todtp_pkg::out_item_t    result
);
    import todtp_pkg::*;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_INVALID = 2'd1,
        ACT_FINAL   = 2'd2
    } action_t;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [6:0] ACC_MAX  = 7'd127;

    function automatic logic [6:0] acc_digit(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] v;
        v = 11'({acc, 3'b000}) + 11'({acc, 1'b0}) + 11'(d);
        return (v > 11'(ACC_MAX)) ? ACC_MAX : v[6:0];
    endfunction

    parse_state_t eff;
    action_t      act;
    action_t      sot_act;
    suffix_t      sot_suffix;
    logic         is_dig;
    logic         is_term;
    logic [3:0]   dval;
    logic [7:0]   dsub;
    logic         hour_ok;
    logic         rest_ok;
    logic [4:0]   hour_out;

    // A start request discards whatever the previous string left behind.
    assign eff     = item.start_req ? STATE_RESET : cur_state;
    assign is_dig  = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    assign dsub    = item.char_code - CH_ZERO;
    assign dval    = dsub[3:0];
    assign is_term = (item.char_code == CH_CR) || (item.char_code == CH_LO_M)
                     || (item.char_code == CH_UP_M);

    // Where the numeric part may stop, a suffix letter or the terminator follows.
    always_comb begin
        sot_suffix = SUF_NONE;
        sot_act    = ACT_INVALID;
        if ((item.char_code == CH_LO_A) || (item.char_code == CH_UP_A)) begin
            sot_suffix = SUF_AM;
            sot_act    = ACT_NONE;
        end else if ((item.char_code == CH_LO_P) || (item.char_code == CH_UP_P)) begin
            sot_suffix = SUF_PM;
            sot_act    = ACT_NONE;
        end else if (is_term) begin
            sot_act = ACT_FINAL;
        end
    end

    // Next-state decode.
    always_comb begin
        state_next = eff;
        act        = ACT_NONE;
        if (!eff.finished) begin
            case (eff.phase)
                PH_HOUR0: begin
                    if (is_dig) begin
                        state_next.hour_acc = acc_digit(eff.hour_acc, dval);
                        state_next.phase    = PH_HOUR;
                    end else begin
                        act = ACT_INVALID;
                    end
                end
                PH_HOUR: begin
                    if (is_dig) begin
                        state_next.hour_acc = acc_digit(eff.hour_acc, dval);
                    end else if (item.char_code == CH_COLON) begin
                        state_next.phase = PH_MIN0;
                    end else begin
                        act = ACT_INVALID;
                    end
                end
                PH_MIN0, PH_MIN: begin
                    if (is_dig) begin
                        state_next.minute_acc = acc_digit(eff.minute_acc, dval);
                        state_next.phase      = PH_MIN;
                    end else if ((eff.phase == PH_MIN) && (item.char_code == CH_COLON)) begin
                        state_next.phase = PH_SEC0;
                    end else begin
                        act = sot_act;
                        if (sot_act == ACT_NONE) begin
                            state_next.suffix = sot_suffix;
                            state_next.phase  = PH_TERM;
                        end
                    end
                end
                PH_SEC0, PH_SEC: begin
                    if (is_dig) begin
                        state_next.second_acc = acc_digit(eff.second_acc, dval);
                        state_next.phase      = PH_SEC;
                    end else if (item.char_code == CH_DOT) begin
                        state_next.phase = PH_HUND0;
                    end else begin
                        act = sot_act;
                        if (sot_act == ACT_NONE) begin
                            state_next.suffix = sot_suffix;
                            state_next.phase  = PH_TERM;
                        end
                    end
                end
                PH_HUND0, PH_HUND: begin
                    if (is_dig) begin
                        state_next.hundredths_acc = acc_digit(eff.hundredths_acc, dval);
                        state_next.phase          = PH_HUND;
                    end else begin
                        act = sot_act;
                        if (sot_act == ACT_NONE) begin
                            state_next.suffix = sot_suffix;
                            state_next.phase  = PH_TERM;
                        end
                    end
                end
                PH_TERM: begin
                    act = is_term ? ACT_FINAL : ACT_INVALID;
                end
                default: begin
                    act = ACT_INVALID;
                end
            endcase
        end
        if (act != ACT_NONE) begin
            state_next.finished = 1'b1;
        end
    end

    // Result: range checks and the 24-hour conversion at the terminator.
    always_comb begin
        case (eff.suffix)
            SUF_NONE: begin
                hour_ok  = eff.hour_acc <= HOUR_MAX_24;
                hour_out = eff.hour_acc[4:0];
            end
            SUF_AM: begin
                hour_ok  = eff.hour_acc <= HOUR_MAX_12;
                hour_out = (eff.hour_acc == HOUR_MAX_12) ? 5'd0 : eff.hour_acc[4:0];
            end
            default: begin
                hour_ok  = (eff.hour_acc != 7'd0) && (eff.hour_acc <= HOUR_MAX_12);
                hour_out = eff.hour_acc[4:0] + HOUR_MAX_12[4:0];
            end
        endcase
        rest_ok = (eff.minute_acc <= MINSEC_MAX) && (eff.second_acc <= MINSEC_MAX)
                  && (eff.hundredths_acc <= HUNDREDTHS_MAX);
        emit    = act != ACT_NONE;
        result  = '0;
        if ((act == ACT_FINAL) && hour_ok && rest_ok) begin
            result.valid_res  = 1'b1;
            result.hour       = hour_out;
            result.minute     = eff.minute_acc[5:0];
            result.second     = eff.second_acc[5:0];
            result.hundredths = eff.hundredths_acc;
        end
    end

endmodule

// ----- rtl/core/time_of_day_text_parser_core.sv -----
// Top level of the time-of-day text parser: input register, parser state, result register.
// Depends on todtp_pkg and todtp_step.

// Takes one character per cycle and gives one result per time string; the character that
// ends it passes the input register, then the result register. Throughput is one
// character per clock; s_ready falls only when the result register holds an untaken
// result and the registered character would produce another one. Raise start_req with
// the first character of each string; after reset the parser already waits for one.
module time_of_day_text_parser_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  todtp_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output todtp_pkg::out_item_t m_data
);
    import todtp_pkg::*;

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    logic         step_emit;
    out_item_t    step_result;
    logic         out_free;
    logic         advance;

    todtp_step u_step (
        .cur_state  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    // The registered character moves on unless its result has nowhere to go.
    assign advance  = in_valid_reg && (!step_emit || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_emit) begin
            out_item_reg <= step_result;
        end
    end

endmodule

// ----- rtl/core/todtp_checker.sv -----
// Port-level checks for the time-of-day text parser core, bound to the top level.
// Depends on todtp_pkg and time_of_day_text_parser_core_defines.svh.
`include "time_of_day_text_parser_core_defines.svh"

module todtp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input todtp_pkg::in_item_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input todtp_pkg::out_item_t m_data
);
    import todtp_pkg::*;

    // A stalled result transfer keeps its payload.
    `TODTP_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data))

    // An accepted time always lies within the legal ranges.
    `TODTP_ASSERT_SAME(a_valid_in_range, m_valid && m_data.valid_res, (m_data.hour <= HOUR_MAX_24[4:0]) && (7'(m_data.minute) <= MINSEC_MAX) && (7'(m_data.second) <= MINSEC_MAX) && (m_data.hundredths <= HUNDREDTHS_MAX))

    // A rejected string reports all fields as zero.
    `TODTP_ASSERT_SAME(a_invalid_zero, m_valid && !m_data.valid_res, (m_data.hour == 5'd0) && (m_data.minute == 6'd0) && (m_data.second == 6'd0) && (m_data.hundredths == 7'd0))

endmodule

bind time_of_day_text_parser_core todtp_checker u_todtp_checker (.*);

// ----- bench/time_of_day_text_parser_core_checker.sv -----
// Checker for the time-of-day text parser core: predicts the result of each time string
// from the accepted character transfers and compares it with the result transfers.
// Depends on todtp_pkg.
module time_of_day_text_parser_core_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  todtp_pkg::in_item_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  todtp_pkg::out_item_t m_data,
    output int                   pending,
    output int                   errors
);
    import todtp_pkg::*;

    localparam logic [7:0] CR = 8'h0D;

    // Predicted parser state.
    phase_t     ph;
    logic [6:0] hour_sum;
    logic [6:0] min_sum;
    logic [6:0] sec_sum;
    logic [6:0] hund_sum;
    suffix_t    am_pm;
    logic       closed;

    out_item_t  times_due[$];

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_term(logic [7:0] c);
        return c == CR || c == "m" || c == "M";
    endfunction

    function automatic logic [6:0] add_digit(logic [6:0] acc, logic [7:0] c);
        int sum;
        sum = int'(acc) * 10 + int'(c) - 48;
        return (sum > 127) ? 7'd127 : sum[6:0];
    endfunction

    function automatic out_item_t time_from_fields();
        out_item_t  r;
        logic [6:0] hh;
        bit         ok;
        r = '0;
        ok = 1'b1;
        hh = hour_sum;
        case (am_pm)
            SUF_NONE: begin
                if (hh > HOUR_MAX_24) ok = 1'b0;
            end
            SUF_AM: begin
                if (hh > HOUR_MAX_12) ok = 1'b0;
                else if (hh == HOUR_MAX_12) hh = 7'd0;
            end
            default: begin
                if (hh < 7'd1 || hh > HOUR_MAX_12) ok = 1'b0;
                else hh = hh + HOUR_MAX_12;
            end
        endcase
        if (min_sum > MINSEC_MAX || sec_sum > MINSEC_MAX || hund_sum > HUNDREDTHS_MAX)
            ok = 1'b0;
        if (ok) begin
            r.valid_res  = 1'b1;
            r.hour       = hh[4:0];
            r.minute     = min_sum[5:0];
            r.second     = sec_sum[5:0];
            r.hundredths = hund_sum;
        end
        return r;
    endfunction

    task clear_parser();
        ph       = PH_HOUR0;
        hour_sum = '0;
        min_sum  = '0;
        sec_sum  = '0;
        hund_sum = '0;
        am_pm    = SUF_NONE;
        closed   = 1'b0;
    endtask

    // Advances the predicted state by one character; has_res is set when the string ends.
    task parse_char(input in_item_t it, output bit has_res, output out_item_t res);
        logic [7:0] c;
        bit         tail;
        bit         stop;
        bit         check;
        c = it.char_code;
        tail = 1'b0;
        stop = 1'b0;
        check = 1'b0;
        has_res = 1'b0;
        res = '0;
        if (it.start_req) clear_parser();
        if (!closed) begin
            case (ph)
                PH_HOUR0: begin
                    if (is_digit(c)) begin
                        hour_sum = add_digit(hour_sum, c);
                        ph = PH_HOUR;
                    end else begin
                        stop = 1'b1;
                    end
                end
                PH_HOUR: begin
                    if (is_digit(c)) hour_sum = add_digit(hour_sum, c);
                    else if (c == ":") ph = PH_MIN0;
                    else stop = 1'b1;
                end
                PH_MIN0, PH_MIN: begin
                    if (is_digit(c)) begin
                        min_sum = add_digit(min_sum, c);
                        ph = PH_MIN;
                    end else if (ph == PH_MIN && c == ":") begin
                        ph = PH_SEC0;
                    end else begin
                        tail = 1'b1;
                    end
                end
                PH_SEC0, PH_SEC: begin
                    if (is_digit(c)) begin
                        sec_sum = add_digit(sec_sum, c);
                        ph = PH_SEC;
                    end else if (c == ".") begin
                        ph = PH_HUND0;
                    end else begin
                        tail = 1'b1;
                    end
                end
                PH_HUND0, PH_HUND: begin
                    if (is_digit(c)) begin
                        hund_sum = add_digit(hund_sum, c);
                        ph = PH_HUND;
                    end else begin
                        tail = 1'b1;
                    end
                end
                PH_TERM: begin
                    stop = 1'b1;
                    check = is_term(c);
                end
                default: stop = 1'b1;
            endcase
            // Wherever the numeric part may stop, a suffix letter or the terminator may follow.
            if (tail) begin
                if (c == "a" || c == "A") begin
                    am_pm = SUF_AM;
                    ph = PH_TERM;
                end else if (c == "p" || c == "P") begin
                    am_pm = SUF_PM;
                    ph = PH_TERM;
                end else begin
                    stop = 1'b1;
                    check = is_term(c);
                end
            end
            if (stop) begin
                has_res = 1'b1;
                closed = 1'b1;
                if (check) res = time_from_fields();
            end
        end
    endtask

    task report(input string field, input int want, input int got);
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t pred;
        bit        got;
        if (!aresetn) begin
            clear_parser();
            times_due.delete();
            pending = 0;
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (times_due.size() == 0) begin
                    $error("m_data: expected no result, got %h", m_data);
                    errors++;
                end else begin
                    want = times_due.pop_front();
                    if (m_data.valid_res !== want.valid_res)
                        report("valid_res", int'(want.valid_res), int'(m_data.valid_res));
                    if (m_data.hour !== want.hour)
                        report("hour", int'(want.hour), int'(m_data.hour));
                    if (m_data.minute !== want.minute)
                        report("minute", int'(want.minute), int'(m_data.minute));
                    if (m_data.second !== want.second)
                        report("second", int'(want.second), int'(m_data.second));
                    if (m_data.hundredths !== want.hundredths)
                        report("hundredths", int'(want.hundredths), int'(m_data.hundredths));
                end
            end
            if (s_valid && s_ready) begin
                parse_char(s_data, got, pred);
                if (got) times_due.push_back(pred);
            end
            pending = times_due.size();
        end
    end

endmodule

// ----- bench/time_of_day_text_parser_core_tb.sv -----
// Top of the time-of-day text parser core testbench: clock, reset, character stimulus,
// result back-pressure and the verdict. Depends on todtp_pkg, the core and its checker.
module time_of_day_text_parser_core_tb;
    import todtp_pkg::*;

    localparam logic [7:0] CR          = 8'h0D;
    localparam int         ITEM_TARGET = 1225;
    localparam int         LONG_HOLD   = 400;
    localparam int         CYCLE_LIMIT = 1000000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int pending;
    int errors;
    int items_sent  = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int cycles      = 0;
    bit calm_tx     = 1'b0;
    bit pressure_done = 1'b0;

    logic [7:0] text_chars[$];

    always #5 aclk = ~aclk;

    time_of_day_text_parser_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    time_of_day_text_parser_core_checker i_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .pending (pending),
        .errors  (errors)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_value(int usual, int wide);
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, usual + 1);
        return $urandom_range(0, wide);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task send_item(input logic [7:0] c, input logic st);
        int gap;
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{char_code: c, start_req: st};
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task send_chars(input bit with_start);
        logic st;
        for (int i = 0; i < text_chars.size(); i++) begin
            st = (i == 0) ? with_start : ($urandom_range(0, 63) == 0);
            send_item(text_chars[i], st);
            items_sent++;
        end
    endtask

    task send_text(input string t, input bit with_start, input bit add_cr);
        text_chars.delete();
        for (int i = 0; i < t.len(); i++) text_chars.push_back(t[i]);
        if (add_cr) text_chars.push_back(CR);
        send_chars(with_start);
    endtask

    task automatic push_number(input int v);
        logic [7:0] digits[$];
        if ($urandom_range(0, 4) == 0) text_chars.push_back("0");
        do begin
            digits.push_front(8'(48 + v % 10));
            v = v / 10;
        end while (v > 0);
        foreach (digits[i]) text_chars.push_back(digits[i]);
    endtask

    // A well-formed time string with random content, sometimes broken afterwards.
    task build_string();
        int idx;
        text_chars.delete();
        push_number(pick_value(24, 2000));
        text_chars.push_back(":");
        if ($urandom_range(0, 4) != 0) begin
            push_number(pick_value(60, 300));
            if ($urandom_range(0, 4) < 3) begin
                text_chars.push_back(":");
                if ($urandom_range(0, 4) != 0) push_number(pick_value(60, 300));
                if ($urandom_range(0, 1) == 0) begin
                    text_chars.push_back(".");
                    if ($urandom_range(0, 4) != 0) push_number(pick_value(99, 300));
                end
            end
        end
        case ($urandom_range(0, 5))
            2: text_chars.push_back("a");
            3: text_chars.push_back("A");
            4: text_chars.push_back("p");
            5: text_chars.push_back("P");
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: text_chars.push_back(CR);
            1: text_chars.push_back("m");
            default: text_chars.push_back("M");
        endcase
        if ($urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, text_chars.size() - 1);
            case ($urandom_range(0, 2))
                0: text_chars[idx] = 8'($urandom_range(0, 255));
                1: while (text_chars.size() > idx + 1) void'(text_chars.pop_back());
                default: text_chars.insert(idx, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Holds the sender back until every expected result has been taken.
    task drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    initial begin : receiver
        int run;
        int stall;
        bit calm;
        run = 0;
        calm = 1'b0;
        wait (aresetn);
        forever begin
            if (holds_done != holds_asked) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                holds_done++;
            end
            if (run == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                run = $urandom_range(20, 200);
            end
            run--;
            stall = calm ? 0 : pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // The parser waits for an hour digit straight after reset; empty minutes count as zero.
        send_text("0:", 1'b0, 1'b1);
        send_text("x", 1'b1, 1'b0);
        // Characters after the end of a string are ignored.
        send_text("5", 1'b0, 1'b0);
        send_text("12:aM", 1'b1, 1'b0);
        // Saturated hours must be rejected.
        send_text("999:P", 1'b1, 1'b1);
        send_text("24:60:60.99m", 1'b1, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
            if (!pressure_done && items_sent > 400) begin
                // The receiver stalls for a long stretch while short strings keep coming.
                holds_asked++;
                calm_tx = 1'b1;
                repeat (40) send_text("1:", 1'b1, 1'b1);
                drain();
                calm_tx = 1'b0;
                pressure_done = 1'b1;
            end
            build_string();
            send_chars($urandom_range(0, 31) != 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 39) == 0) drain();
        end

        drain();
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
